### rtl/core/ast_pkg.sv
`default_nettype none

package ast_pkg;

  localparam int NUM_BANKS_DEF   = 64;
  localparam int NUM_THREADS_DEF = 16;

  localparam int MODE_W  = 2;
  localparam int BANK_W  = 6;
  localparam int TID_W   = 4;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 7;
  localparam int PHASE_W = 24;

  localparam int MODE_ACT_BIT = 0;
  localparam int MODE_PRE_BIT = 1;

  localparam logic [CNT_W-1:0]   CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};
  localparam logic [PHASE_W-1:0] QLEN_RESET   = 24'd10000000;
  localparam int                 QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic              act;
    logic              pre;
    logic [BANK_W-1:0] bank;
    logic [TID_W-1:0]  tid;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/attained_service_tracker_unit.sv
`default_nettype none

// Attained-service tracker. Each request on the command channel is one
// controller tick: start with mode, bank and thread_id is taken when busy is
// low. Busy rises only when the two-entry request queue is full.
// Every tick adds each thread's owned-bank count to its service sum and then
// applies the activate and precharge of the request to bank ownership.
// When the tick count reaches the configured quantum length, the sums of all
// NUM_THREADS threads are reported in thread order, one per cycle with strobe
// high, the final one with last high, and the sums are cleared.
// A tick runs through the queue and a back end (owner memory read, then
// update), so one request per cycle is sustained while no report holds it.
// A quantum end that arrives while a report still drains waits for it, so
// ticks stall and busy rises once the queue is full. The request that ends
// the quantum loads the report buffer, whose head is registered to the ports.
// The receiver cannot stall; every strobe is one accepted result.
// The quantum length is written through cfg_valid, cfg_ready and cfg_data;
// cfg_ready is always high. Reset clears ownership, counts, sums and the
// tick count, and sets the quantum length to 10000000.
module attained_service_tracker_unit #(
  parameter int NUM_BANKS   = ast_pkg::NUM_BANKS_DEF,
  parameter int NUM_THREADS = ast_pkg::NUM_THREADS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [ast_pkg::MODE_W-1:0]  mode,
  input  wire logic [ast_pkg::BANK_W-1:0]  bank,
  input  wire logic [ast_pkg::TID_W-1:0]   thread_id,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ast_pkg::PHASE_W-1:0] cfg_data,
  output logic                             strobe,
  output logic      [ast_pkg::TID_W-1:0]   report_thread,
  output logic      [ast_pkg::SUM_W-1:0]   attained_service,
  output logic                             last
);

  import ast_pkg::*;

  logic [PHASE_W-1:0] quantum_ticks;
  logic               q_valid;
  cmd_t               q_cmd;
  logic               q_pop;
  logic               rep_busy;
  logic               rep_load;
  logic [SUM_W-1:0]   snap [NUM_THREADS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_ticks <= QLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      quantum_ticks <= cfg_data;
    end
  end

  ast_front #(
    .NUM_BANKS   (NUM_BANKS),
    .NUM_THREADS (NUM_THREADS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .bank      (bank),
    .thread_id (thread_id),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  ast_back #(
    .NUM_BANKS   (NUM_BANKS),
    .NUM_THREADS (NUM_THREADS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .qlen     (quantum_ticks),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .rep_busy (rep_busy),
    .rep_load (rep_load),
    .snap     (snap)
  );

  ast_report #(
    .NUM_THREADS (NUM_THREADS)
  ) u_report (
    .clk              (clk),
    .rst              (rst),
    .load             (rep_load),
    .snap             (snap),
    .rep_busy         (rep_busy),
    .strobe           (strobe),
    .report_thread    (report_thread),
    .attained_service (attained_service),
    .last             (last)
  );

endmodule

`default_nettype wire

### rtl/core/ast_ram.sv
`default_nettype none

module ast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/ast_front.sv
`default_nettype none

module ast_front #(
  parameter int NUM_BANKS   = ast_pkg::NUM_BANKS_DEF,
  parameter int NUM_THREADS = ast_pkg::NUM_THREADS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ast_pkg::MODE_W-1:0] mode,
  input  wire logic [ast_pkg::BANK_W-1:0] bank,
  input  wire logic [ast_pkg::TID_W-1:0]  thread_id,
  output logic                            q_valid,
  output ast_pkg::cmd_t                   q_cmd,
  input  wire logic                       q_pop
);

  import ast_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slots [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;
  logic           bank_ok;
  logic           tid_ok;
  cmd_t           cmd_in;

  assign busy    = (count == QCW'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign pop     = q_pop && q_valid;
  assign q_cmd   = slots[rd_ptr];

  assign bank_ok = (32'(bank) < NUM_BANKS);
  assign tid_ok  = (32'(thread_id) < NUM_THREADS);

  always_comb begin
    cmd_in.act  = mode[MODE_ACT_BIT] && bank_ok && tid_ok;
    cmd_in.pre  = mode[MODE_PRE_BIT] && bank_ok;
    cmd_in.bank = bank;
    cmd_in.tid  = thread_id;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count != '0))
    else $error("Queue lost a request.");

endmodule

`default_nettype wire

### rtl/core/ast_back.sv
`default_nettype none

module ast_back #(
  parameter int NUM_BANKS   = ast_pkg::NUM_BANKS_DEF,
  parameter int NUM_THREADS = ast_pkg::NUM_THREADS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ast_pkg::PHASE_W-1:0] qlen,
  input  wire logic                        q_valid,
  input  wire ast_pkg::cmd_t               q_cmd,
  output logic                             q_pop,
  input  wire logic                        rep_busy,
  output logic                             rep_load,
  output logic      [ast_pkg::SUM_W-1:0]   snap [NUM_THREADS]
);

  import ast_pkg::*;

  localparam int BANK_AW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  logic               b_valid;
  cmd_t               b_cmd;
  logic               b_done;
  logic               stall;
  logic [BANK_AW-1:0] b_addr;
  logic [BANK_AW-1:0] raddr;
  logic [TID_W-1:0]   rdata;
  logic               wen;
  logic               fwd;
  logic [TID_W-1:0]   fwd_data;
  logic [TID_W-1:0]   own_old;
  logic               old_v;
  logic               new_v;
  logic [TID_W-1:0]   own_new;
  logic               owner_valid [NUM_BANKS];
  logic [CNT_W-1:0]   active [NUM_THREADS];
  logic [CNT_W-1:0]   active_next [NUM_THREADS];
  logic [SUM_W-1:0]   sums [NUM_THREADS];
  logic [SUM_W-1:0]   grown [NUM_THREADS];
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_inc;
  logic               report_now;

  assign phase_inc  = phase + 1'b1;
  assign report_now = (phase_inc >= qlen);
  assign stall      = b_valid && report_now && rep_busy;
  assign b_done     = b_valid && !stall;
  assign q_pop      = q_valid && (!b_valid || b_done);
  assign rep_load   = b_done && report_now;

  assign b_addr = BANK_AW'(b_cmd.bank);
  assign raddr  = q_pop ? BANK_AW'(q_cmd.bank) : b_addr;
  assign wen    = b_done && b_cmd.act;

  ast_ram #(
    .WIDTH (TID_W),
    .DEPTH (NUM_BANKS)
  ) u_owner_ram (
    .clk   (clk),
    .we    (wen),
    .waddr (b_addr),
    .wdata (b_cmd.tid),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign own_old = fwd ? fwd_data : rdata;
  assign old_v   = (b_cmd.act || b_cmd.pre) && owner_valid[b_addr];
  assign new_v   = b_cmd.act || old_v;
  assign own_new = b_cmd.act ? b_cmd.tid : own_old;

  // Each thread's count replays the model order: old owner loses, new owner
  // gains, then a precharge takes the bank from whoever holds it.
  always_comb begin
    logic [CNT_W-1:0]   c1;
    logic [CNT_W-1:0]   c2;
    logic [SUM_W:0]     wide;
    for (int t = 0; t < NUM_THREADS; t++) begin
      c1 = active[t];
      if (b_cmd.act && old_v && (int'(own_old) == t) && (c1 != '0)) begin
        c1 = c1 - 1'b1;
      end
      c2 = c1;
      if (b_cmd.act && (int'(b_cmd.tid) == t) && (c2 != CNT_MAX)) begin
        c2 = c2 + 1'b1;
      end
      if (b_cmd.pre && new_v && (int'(own_new) == t) && (c2 != '0)) begin
        c2 = c2 - 1'b1;
      end
      active_next[t] = c2;
      wide = {1'b0, sums[t]} + (SUM_W + 1)'(active[t]);
      grown[t] = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
      snap[t]  = grown[t];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_cmd <= q_cmd;
    end
    fwd_data <= b_cmd.tid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd     <= 1'b0;
      phase   <= '0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        owner_valid[i] <= 1'b0;
      end
      for (int t = 0; t < NUM_THREADS; t++) begin
        active[t] <= '0;
        sums[t]   <= '0;
      end
    end else begin
      fwd <= wen && (raddr == b_addr);
      if (q_pop) begin
        b_valid <= 1'b1;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (b_done) begin
        phase <= report_now ? '0 : phase_inc;
        if (b_cmd.act || b_cmd.pre) begin
          owner_valid[b_addr] <= new_v && !b_cmd.pre;
        end
        for (int t = 0; t < NUM_THREADS; t++) begin
          active[t] <= active_next[t];
          sums[t]   <= report_now ? '0 : grown[t];
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_done) |-> (rep_busy && report_now))
    else $error("Tick held back without a pending report.");

  assert property (@(posedge clk) disable iff (rst)
    rep_load |-> !rep_busy)
    else $error("Report started while the previous one drains.");

endmodule

`default_nettype wire

### rtl/core/ast_report.sv
`default_nettype none

module ast_report #(
  parameter int NUM_THREADS = ast_pkg::NUM_THREADS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire logic [ast_pkg::SUM_W-1:0] snap [NUM_THREADS],
  output logic                           rep_busy,
  output logic                           strobe,
  output logic      [ast_pkg::TID_W-1:0] report_thread,
  output logic      [ast_pkg::SUM_W-1:0] attained_service,
  output logic                           last
);

  import ast_pkg::*;

  localparam int IW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

  logic [SUM_W-1:0] buffer [NUM_THREADS];
  logic [IW-1:0]    idx;
  logic             active;
  logic             at_end;

  assign rep_busy = active;
  assign at_end   = (idx == IW'(NUM_THREADS - 1));

  always_ff @(posedge clk) begin
    if (load) begin
      for (int t = 0; t < NUM_THREADS; t++) begin
        buffer[t] <= snap[t];
      end
    end else if (active) begin
      for (int t = 0; t < NUM_THREADS - 1; t++) begin
        buffer[t] <= buffer[t + 1];
      end
    end
    report_thread    <= TID_W'(idx);
    attained_service <= buffer[0];
    last             <= at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (load) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        if (at_end) begin
          active <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    load |=> rep_busy)
    else $error("Report did not start after load.");

  assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("Report stream broke before its last entry.");

  assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("Report continued past its last entry.");

endmodule

`default_nettype wire
